[hw/rtl/i2cwr_pkg.sv]
// ----------------------------------------------------------------------------
// i2cwr_pkg
// Shared types and codes for the I2C write/read transaction sequencer.
// ----------------------------------------------------------------------------
package i2cwr_pkg;

  localparam int unsigned AddrW = 7;
  localparam int unsigned LenW  = 16;

  typedef enum logic [2:0] {
    FN_START  = 3'd0,
    FN_CTRL   = 3'd1,
    FN_ERR    = 3'd2,
    FN_TX_DMA = 3'd3,
    FN_RX_DMA = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    DMA_HALF = 2'd0,
    DMA_DONE = 2'd1,
    DMA_FAIL = 2'd2
  } dma_ev_t;

  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_TX_FAIL = 2'd1,
    RC_RX_FAIL = 2'd2,
    RC_NO_ACK  = 2'd3
  } result_t;

  // one result transaction
  typedef struct packed {
    logic            issue_start;
    logic            issue_stop;
    logic            addr_byte_valid;
    logic [7:0]      addr_byte;
    logic            tx_dma_start;
    logic            rx_dma_start;
    logic [LenW-1:0] dma_len;
    logic            ack_enable;
    logic            dma_abort;
    logic            dr_read;
    logic            done_res;
    logic [1:0]      result_code;
  } res_t;

endpackage

[hw/rtl/i2cwr_if.sv]
// ----------------------------------------------------------------------------
// i2cwr_if
// Event and result channels (valid/ready) of the transaction sequencer.
// ----------------------------------------------------------------------------
interface i2cwr_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [6:0]  dev_addr;
  logic [15:0] tx_len;
  logic [15:0] rx_len;
  logic        flag_sb;
  logic        flag_addr;
  logic        flag_btf;
  logic        flag_af;
  logic        flag_ovr;
  logic        flag_arlo;
  logic        flag_berr;
  logic [1:0]  dma_event;

  modport source (
    output valid, func, dev_addr, tx_len, rx_len, flag_sb, flag_addr, flag_btf,
           flag_af, flag_ovr, flag_arlo, flag_berr, dma_event,
    input  ready
  );
  modport sink (
    input  valid, func, dev_addr, tx_len, rx_len, flag_sb, flag_addr, flag_btf,
           flag_af, flag_ovr, flag_arlo, flag_berr, dma_event,
    output ready
  );
endinterface

interface i2cwr_res_if;
  logic        valid;
  logic        ready;
  logic        issue_start;
  logic        issue_stop;
  logic        addr_byte_valid;
  logic [7:0]  addr_byte;
  logic        tx_dma_start;
  logic        rx_dma_start;
  logic [15:0] dma_len;
  logic        ack_enable;
  logic        dma_abort;
  logic        dr_read;
  logic        done_res;
  logic [1:0]  result_code;

  modport source (
    output valid, issue_start, issue_stop, addr_byte_valid, addr_byte,
           tx_dma_start, rx_dma_start, dma_len, ack_enable, dma_abort, dr_read,
           done_res, result_code,
    input  ready
  );
  modport sink (
    input  valid, issue_start, issue_stop, addr_byte_valid, addr_byte,
           tx_dma_start, rx_dma_start, dma_len, ack_enable, dma_abort, dr_read,
           done_res, result_code,
    output ready
  );
endinterface

[hw/rtl/i2cwr_ctrl.sv]
// ----------------------------------------------------------------------------
// i2cwr_ctrl
// Transaction state and per-event command decode.
// ----------------------------------------------------------------------------
module i2cwr_ctrl
  import i2cwr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  i2cwr_evt_if.sink     evt,
  input  logic          load_ok,
  output logic          res_load,
  output res_t          res_data
);

  logic [AddrW-1:0] target_addr, target_addr_next;
  logic [LenW-1:0]  write_len, write_len_next;
  logic [LenW-1:0]  read_len, read_len_next;
  logic             write_pending, write_pending_next;
  logic             read_pending, read_pending_next;
  logic             busy, busy_next;
  logic             accept;

  assign evt.ready = load_ok;
  assign accept    = evt.valid && evt.ready;
  assign res_load  = accept;

  always_comb begin
    target_addr_next   = target_addr;
    write_len_next     = write_len;
    read_len_next      = read_len;
    write_pending_next = write_pending;
    read_pending_next  = read_pending;
    busy_next          = busy;
    res_data           = '0;

    if (func_t'(evt.func) == FN_START) begin
      if (!busy) begin
        target_addr_next   = evt.dev_addr;
        write_len_next     = evt.tx_len;
        read_len_next      = evt.rx_len;
        write_pending_next = (evt.tx_len != '0);
        read_pending_next  = (evt.rx_len != '0);
        if ((evt.tx_len != '0) || (evt.rx_len != '0)) begin
          busy_next            = 1'b1;
          res_data.issue_start = 1'b1;
        end else begin
          // empty request completes at once
          res_data.done_res    = 1'b1;
          res_data.result_code = RC_OK;
        end
      end
    end else if (busy) begin
      case (func_t'(evt.func))
        FN_CTRL: begin
          if (evt.flag_sb) begin
            res_data.addr_byte_valid = 1'b1;
            res_data.addr_byte       = {target_addr, ~write_pending};
          end else if (evt.flag_addr) begin
            if (write_pending) begin
              res_data.tx_dma_start = 1'b1;
              res_data.dma_len      = write_len;
            end else if (read_pending) begin
              res_data.rx_dma_start = 1'b1;
              res_data.dma_len      = read_len;
              res_data.ack_enable   = |read_len[LenW-1:1];
            end
          end else if (evt.flag_btf) begin
            res_data.dr_read = 1'b1;
          end
        end
        FN_ERR: begin
          if (evt.flag_af || evt.flag_ovr || evt.flag_arlo || evt.flag_berr) begin
            write_len_next       = '0;
            read_len_next        = '0;
            write_pending_next   = 1'b0;
            read_pending_next    = 1'b0;
            busy_next            = 1'b0;
            res_data.dma_abort   = 1'b1;
            res_data.issue_stop  = 1'b1;
            res_data.done_res    = 1'b1;
            if (evt.flag_af)       res_data.result_code = RC_NO_ACK;
            else if (evt.flag_ovr) res_data.result_code = RC_RX_FAIL;
            else                   res_data.result_code = RC_TX_FAIL;
          end
        end
        FN_TX_DMA, FN_RX_DMA: begin
          if (dma_ev_t'(evt.dma_event) == DMA_DONE) begin
            if (func_t'(evt.func) == FN_TX_DMA) begin
              write_pending_next = 1'b0;
              write_len_next     = '0;
            end else begin
              read_pending_next = 1'b0;
              read_len_next     = '0;
            end
            if ((func_t'(evt.func) == FN_TX_DMA) && read_pending) begin
              // repeated start into the read phase
              res_data.issue_start = 1'b1;
            end else begin
              busy_next            = 1'b0;
              res_data.issue_stop  = 1'b1;
              res_data.done_res    = 1'b1;
              res_data.result_code = RC_OK;
            end
          end else if (dma_ev_t'(evt.dma_event) == DMA_FAIL) begin
            write_len_next       = '0;
            read_len_next        = '0;
            write_pending_next   = 1'b0;
            read_pending_next    = 1'b0;
            busy_next            = 1'b0;
            res_data.dma_abort   = 1'b1;
            res_data.issue_stop  = 1'b1;
            res_data.done_res    = 1'b1;
            res_data.result_code = (func_t'(evt.func) == FN_TX_DMA) ?
                                   RC_TX_FAIL : RC_RX_FAIL;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_addr   <= '0;
      write_len     <= '0;
      read_len      <= '0;
      write_pending <= 1'b0;
      read_pending  <= 1'b0;
      busy          <= 1'b0;
    end else if (accept) begin
      target_addr   <= target_addr_next;
      write_len     <= write_len_next;
      read_len      <= read_len_next;
      write_pending <= write_pending_next;
      read_pending  <= read_pending_next;
      busy          <= busy_next;
    end
  end

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    accept && !busy && res_data.issue_start |=> busy)
    else $error("start issued but sequencer not busy");

  a_idle_ignores: assert property (@(posedge clk) disable iff (rst)
    accept && !busy && (func_t'(evt.func) != FN_START) |-> res_data == '0)
    else $error("command produced while idle");

  a_done_clears_busy: assert property (@(posedge clk) disable iff (rst)
    accept && busy && res_data.done_res |=> !busy)
    else $error("busy held after completion");

  a_abort_completes: assert property (@(posedge clk) disable iff (rst)
    res_data.dma_abort |-> res_data.issue_stop && res_data.done_res)
    else $error("abort without stop and completion");

  a_ack_only_read: assert property (@(posedge clk) disable iff (rst)
    res_data.ack_enable |-> res_data.rx_dma_start && (res_data.dma_len > 16'd1))
    else $error("ack enable outside read DMA start");

endmodule

[hw/rtl/i2cwr_out_reg.sv]
// ----------------------------------------------------------------------------
// i2cwr_out_reg
// Result register that decouples the result channel from the event channel.
// ----------------------------------------------------------------------------
module i2cwr_out_reg
  import i2cwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_t        load_data,
  output logic        load_ok,
  i2cwr_res_if.source res
);

  logic valid;
  res_t data;

  // a new result may land when the slot is empty or is emptied this cycle
  assign load_ok = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

  assign res.valid           = valid;
  assign res.issue_start     = data.issue_start;
  assign res.issue_stop      = data.issue_stop;
  assign res.addr_byte_valid = data.addr_byte_valid;
  assign res.addr_byte       = data.addr_byte;
  assign res.tx_dma_start    = data.tx_dma_start;
  assign res.rx_dma_start    = data.rx_dma_start;
  assign res.dma_len         = data.dma_len;
  assign res.ack_enable      = data.ack_enable;
  assign res.dma_abort       = data.dma_abort;
  assign res.dr_read         = data.dr_read;
  assign res.done_res        = data.done_res;
  assign res.result_code     = data.result_code;

endmodule

[hw/rtl/i2c_write_read_transaction_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// i2c_write_read_transaction_sequencer_unit
// Sequencer for an I2C master write, repeated start, read transaction.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries one event per transaction: a start request (address and
//   lengths), a controller event, an error-flag event or a DMA event.
//   res carries exactly one result transaction per event: the commands for
//   the controller and the DMA channels, plus completion and result code.
//   The result is valid in the cycle after the event is accepted.
//   Throughput: one event per cycle unless res stalls; state is updated in the
//   same cycle the command is decoded, so back-to-back events see it.
//   A single result register sits on the output; evt.ready stays high while
//   that register is empty or being drained, so a stalled receiver holds
//   evt.ready low only while an unread result is waiting.
//   Reset (rst, synchronous): sequencer idle, address, lengths and pending
//   marks cleared, result register empty.
// ----------------------------------------------------------------------------
module i2c_write_read_transaction_sequencer_unit
  import i2cwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  i2cwr_evt_if.sink   evt,
  i2cwr_res_if.source res
);

  logic load_ok;
  logic res_load;
  res_t res_data;

  i2cwr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .load_ok  (load_ok),
    .res_load (res_load),
    .res_data (res_data)
  );

  i2cwr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_data (res_data),
    .load_ok   (load_ok),
    .res       (res)
  );

endmodule
